/* hdl/sbda_pkg.sv */
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and controller/datapath interface types for the signed
// binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int INPUT_WIDTH       = 64;
  localparam int VALUE_WIDTH_DEF   = 64;
  localparam int CHAR_WIDTH        = 6;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic top_zero;
    logic last_digit;
    logic negative;
    logic out_free;
  } sts_t;

endpackage

/* hdl/sbda_dp.sv */
// ----------------------------------------------------------------------------
// sbda_dp
// Datapath: magnitude register, double-dabble bcd register, leading zero
// removal and the output character register.
// ----------------------------------------------------------------------------
module sbda_dp #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sbda_pkg::INPUT_WIDTH-1:0] value,
  input  sbda_pkg::cmd_t                cmd,
  output sbda_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbda_pkg::CHAR_WIDTH-1:0] ascii_char,
  output logic                          last_char
);
  import sbda_pkg::*;

  localparam int NDIG   = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W  = 4 * NDIG;
  localparam int BCNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DCNT_W = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCNT_W-1:0]      bit_cnt;
  logic [DCNT_W-1:0]      dig_cnt;
  logic                   negative;
  logic [3:0]             top_digit;

  assign raw       = value[VALUE_WIDTH-1:0];
  assign mag       = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  assign top_digit = bcd[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= mag;
      bcd      <= '0;
      negative <= raw[VALUE_WIDTH-1];
      bit_cnt  <= BCNT_W'(VALUE_WIDTH);
      dig_cnt  <= DCNT_W'(NDIG);
    end else if (cmd.shift) begin
      bcd     <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
      bin     <= {bin[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCNT_W'(1);
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= CHAR_MINUS;
      last_char  <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= CHAR_ZERO + {2'b00, top_digit};
      last_char  <= (dig_cnt == DCNT_W'(1));
    end
  end

  always_comb begin
    sts.last_bit   = (bit_cnt == BCNT_W'(1));
    sts.top_zero   = (top_digit == 4'd0);
    sts.last_digit = (dig_cnt == DCNT_W'(1));
    sts.negative   = negative;
    sts.out_free   = !out_valid || !out_stall;
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid || !out_stall))
    else $error("character written over a waiting beat");
  a_skip_keeps_one: assert property (@(posedge clk) disable iff (rst)
    cmd.skip |-> (dig_cnt > DCNT_W'(1)))
    else $error("leading zero removal took the last digit");
  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (dig_cnt != '0) && (top_digit <= 4'd9))
    else $error("digit emitted with no digit left or bad bcd");
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_char) |-> (ascii_char >= CHAR_ZERO) && (ascii_char <= 6'd57))
    else $error("final beat is not a digit");
`endif

endmodule

/* hdl/sbda_ctrl.sv */
// ----------------------------------------------------------------------------
// sbda_ctrl
// Controller: sequences load, conversion, leading zero removal and the
// emission of the sign and digit characters.
// ----------------------------------------------------------------------------
module sbda_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbda_pkg::sts_t sts,
  output sbda_pkg::cmd_t cmd
);
  import sbda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (sts.last_bit) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts.top_zero && !sts.last_digit) begin
          cmd.skip = 1'b1;
        end else if (sts.negative) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.last_digit) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/signed_binary_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed integer to its decimal ascii text, one character a beat.
// ----------------------------------------------------------------------------
// One value is taken at a time, read as two's complement in its low
// VALUE_WIDTH bits. The block stalls its input while busy: a load, a
// double-dabble pass over the VALUE_WIDTH bits (one bit each), removal of
// leading zero digits down to the last one, then the characters, each sent
// when the output is free, with a '-' first for negative values and
// last_char set on the final digit. The removed and sent digits together
// always number 20 for 64 bits. The final character waits in the output
// register, so the next value is accepted in the cycle after it is written.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sbda_pkg::INPUT_WIDTH-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sbda_pkg::CHAR_WIDTH-1:0]  ascii_char,
  output logic                             last_char
);
  import sbda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbda_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule
